[src/vsrp_pkg.sv]
// ----------------------------------------------------------------------------
// vsrp_pkg
// Shared sizes, codes and types of the voxel cell table with ray picking.
// ----------------------------------------------------------------------------
package vsrp_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int COORD_BITS  = 10;

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int ENT_W  = 3 * COORD_BITS + 1;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int CS_W   = 31;
	localparam int Q_W    = 32;
	localparam int B_W    = Q_W + 1;
	localparam int LO_W   = COORD_BITS + 34;
	localparam int LO_H   = LO_W / 2;
	localparam int HI_H   = LO_W - LO_H;
	localparam int PROD_W = LO_W + B_W;
	localparam int DIV_W  = LO_W + 16;
	localparam int DCNT_W = $clog2(DIV_W + 1);

	localparam logic [1:0] CMD_ADD  = 2'd0;
	localparam logic [1:0] CMD_DEL  = 2'd1;
	localparam logic [1:0] CMD_PICK = 2'd2;
	localparam logic [1:0] CMD_NOP  = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_HIT  = 2'd2;
	localparam logic [1:0] ST_MISS = 2'd3;

	localparam logic [1:0] REG_CELL_SIZE = 2'd0;
	localparam logic [1:0] REG_ORG_X     = 2'd1;
	localparam logic [1:0] REG_ORG_Y     = 2'd2;
	localparam logic [1:0] REG_ORG_Z     = 2'd3;

	localparam logic [CS_W-1:0] CELL_SIZE_RST = CS_W'(65536);
	localparam logic [2:0]      FACE_LAST     = 3'd5;
	localparam logic [Q_W-1:0]  DEPTH_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [Q_W-1:0]  DEPTH_NEG_MAX = 32'h8000_0000;

	typedef logic signed [LO_W-1:0]   lo_t;
	typedef logic signed [B_W-1:0]    opb_t;
	typedef logic signed [PROD_W-1:0] prod_t;

endpackage

[src/voxel_set_ray_pick.sv]
// ----------------------------------------------------------------------------
// voxel_set_ray_pick
// Voxel cell table with add, delete and nearest-face ray pick.
// ----------------------------------------------------------------------------
// Requests enter on start while busy is low; command selects add, delete,
// pick or no-op. Each request gives one result on status, entry_index, face
// and hit_depth, marked by done for one cycle; busy falls in that cycle and a
// new request may be taken at its end. The receiver cannot stall.
// Registers cell_size and grid_origin_x/y/z sit on the APB port (pready high).
// Cells live in one synchronous table memory read one entry per scan step.
// Add and delete scan the filled entries one by one and stop at a match.
// No-op skips the scan.
// Pick visits every filled entry: an inactive one is only read; an active one
// gets its corner offsets and then, for each face whose direction is nonzero,
// eight products from the shared split multiplier (zero-direction faces skip).
// A miss shows once the scan ends; a hit adds a radix-2 depth division
// over DIV_W (60) quotient bits and an output state.
// Reset empties the table at once (count_q cleared, no clearing pass)
// and restores cell_size to 1.0 and the grid origin to zero.
// ----------------------------------------------------------------------------
module voxel_set_ray_pick import vsrp_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ADDR_W-1:0]            paddr,
	input  logic [DATA_W-1:0]            pwdata,
	output logic [DATA_W-1:0]            prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   command,
	input  logic signed [COORD_BITS-1:0] cell_x,
	input  logic signed [COORD_BITS-1:0] cell_y,
	input  logic signed [COORD_BITS-1:0] cell_z,
	input  logic signed [Q_W-1:0]        ray_origin_x,
	input  logic signed [Q_W-1:0]        ray_origin_y,
	input  logic signed [Q_W-1:0]        ray_origin_z,
	input  logic signed [Q_W-1:0]        ray_dir_x,
	input  logic signed [Q_W-1:0]        ray_dir_y,
	input  logic signed [Q_W-1:0]        ray_dir_z,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [IDX_W-1:0]             entry_index,
	output logic [2:0]                   face,
	output logic signed [Q_W-1:0]        hit_depth
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FETCH = 4'd1;
	localparam logic [3:0] S_CHECK = 4'd2;
	localparam logic [3:0] S_LO    = 4'd3;
	localparam logic [3:0] S_FACE  = 4'd4;
	localparam logic [3:0] S_MUL   = 4'd5;
	localparam logic [3:0] S_DEC   = 4'd6;
	localparam logic [3:0] S_END   = 4'd7;
	localparam logic [3:0] S_DIV   = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;
	localparam int         N_PROD  = 8;

	logic [CS_W-1:0]       cs_q;
	logic signed [Q_W-1:0] org_x_q, org_y_q, org_z_q;

	logic [3:0]                   state_q;
	logic [1:0]                   cmd_q;
	logic signed [COORD_BITS-1:0] cx_q, cy_q, cz_q;
	logic signed [Q_W-1:0]        src_x_q, src_y_q, src_z_q;
	logic signed [Q_W-1:0]        dir_x_q, dir_y_q, dir_z_q;
	logic [IDX_W-1:0]             idx_q;
	logic [CNT_W-1:0]             count_q;
	logic signed [COORD_BITS-1:0] ent_x_q, ent_y_q, ent_z_q;
	logic [1:0]                   ax_q;
	logic [2:0]                   face_q;
	logic [3:0]                   step_q;
	lo_t                          lo_x_q, lo_y_q, lo_z_q;
	lo_t                          n_q, q1_q, q1c_q, q2_q, q2c_q;
	opb_t                         d_q, db1_q, db2_q;
	logic signed [LO_H+B_W:0]     pl_q;
	prod_t                        prod_q [N_PROD];
	logic                         found_q;
	lo_t                          best_n_q;
	opb_t                         best_d_q;
	logic [IDX_W-1:0]             best_i_q;
	logic [2:0]                   best_f_q;
	logic [B_W-1:0]               rem_q;
	logic [DIV_W-1:0]             dq_q;
	logic [DCNT_W-1:0]            dcnt_q;
	logic                         done_q;
	logic [1:0]                   status_q;
	logic [IDX_W-1:0]             eidx_q;
	logic [2:0]                   face_out_q;
	logic signed [Q_W-1:0]        depth_q;

	logic [ENT_W-1:0] mem [TABLE_DEPTH];
	logic [ENT_W-1:0] rd_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [ENT_W-1:0] mem_wd;

	logic                         rd_act;
	logic signed [COORD_BITS-1:0] rd_x, rd_y, rd_z;
	logic                         rd_match, last_entry, room;
	logic                         accept, cfg_wr;

	logic signed [COORD_BITS-1:0] ent_sel;
	logic signed [Q_W-1:0]        org_sel, src_sel;
	logic signed [Q_W+COORD_BITS:0] cs_prod;
	lo_t                          lo_new;

	logic [1:0]            fa;
	lo_t                   lo_a, lo_b1, lo_b2, n_raw, cs_ext;
	logic signed [Q_W-1:0] dir_a, dir_b1, dir_b2;
	opb_t                  dir_a_ext;

	lo_t                      op_a;
	opb_t                     op_b;
	logic signed [LO_H+B_W:0] pp_lo;
	logic signed [HI_H+B_W-1:0] pp_hi;
	logic [2:0]               pk;

	logic in_box, better;
	logic [LO_W-1:0]  best_mag;
	logic [B_W:0]     rs;
	logic [B_W:0]     rs_sub;
	logic             big_q;

	assign pready      = 1'b1;
	assign busy        = (state_q != S_IDLE);
	assign accept      = start && !busy;
	assign cfg_wr      = psel && penable && pwrite && pready;
	assign done        = done_q;
	assign status      = status_q;
	assign entry_index = eidx_q;
	assign face        = face_out_q;
	assign hit_depth   = depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q    <= CELL_SIZE_RST;
			org_x_q <= '0;
			org_y_q <= '0;
			org_z_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_CELL_SIZE: cs_q    <= pwdata[CS_W-1:0];
				REG_ORG_X:     org_x_q <= pwdata;
				REG_ORG_Y:     org_y_q <= pwdata;
				REG_ORG_Z:     org_z_q <= pwdata;
				default:       cs_q    <= cs_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_CELL_SIZE: prdata = {1'b0, cs_q};
			REG_ORG_X:     prdata = org_x_q;
			REG_ORG_Y:     prdata = org_y_q;
			REG_ORG_Z:     prdata = org_z_q;
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[idx_q];
	end

	assign {rd_act, rd_z, rd_y, rd_x} = rd_q;
	assign rd_match   = (rd_x == cx_q) && (rd_y == cy_q) && (rd_z == cz_q);
	assign last_entry = ((CNT_W'(idx_q) + 1'b1) == count_q);
	assign room       = (count_q < CNT_W'(TABLE_DEPTH));

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = {cmd_q == CMD_ADD, rd_z, rd_y, rd_x};
		if (state_q == S_CHECK && cmd_q != CMD_PICK && rd_match) begin
			mem_we = 1'b1;
		end else if (state_q == S_END && cmd_q == CMD_ADD && room) begin
			mem_we = 1'b1;
			mem_wa = IDX_W'(count_q);
			mem_wd = {1'b1, cz_q, cy_q, cx_q};
		end
	end

	always_comb begin
		case (ax_q)
			2'd0:    begin ent_sel = ent_x_q; org_sel = org_x_q; src_sel = src_x_q; end
			2'd1:    begin ent_sel = ent_y_q; org_sel = org_y_q; src_sel = src_y_q; end
			default: begin ent_sel = ent_z_q; org_sel = org_z_q; src_sel = src_z_q; end
		endcase
		cs_prod = $signed({1'b0, cs_q}) * ent_sel;
		lo_new  = lo_t'(org_sel) + lo_t'(cs_prod) - lo_t'(src_sel);
	end

	assign fa     = face_q[2:1];
	assign cs_ext = lo_t'($signed({1'b0, cs_q}));

	always_comb begin
		case (fa)
			2'd0: begin
				lo_a = lo_x_q; dir_a = dir_x_q;
				lo_b1 = lo_y_q; dir_b1 = dir_y_q; lo_b2 = lo_z_q; dir_b2 = dir_z_q;
			end
			2'd1: begin
				lo_a = lo_y_q; dir_a = dir_y_q;
				lo_b1 = lo_x_q; dir_b1 = dir_x_q; lo_b2 = lo_z_q; dir_b2 = dir_z_q;
			end
			default: begin
				lo_a = lo_z_q; dir_a = dir_z_q;
				lo_b1 = lo_x_q; dir_b1 = dir_x_q; lo_b2 = lo_y_q; dir_b2 = dir_y_q;
			end
		endcase
		n_raw     = face_q[0] ? lo_a + cs_ext : lo_a;
		dir_a_ext = opb_t'(dir_a);
	end

	assign pk = step_q[3:1];

	always_comb begin
		case (pk)
			3'd0:    begin op_a = q1_q;     op_b = d_q;      end
			3'd1:    begin op_a = n_q;      op_b = db1_q;    end
			3'd2:    begin op_a = q1c_q;    op_b = d_q;      end
			3'd3:    begin op_a = q2_q;     op_b = d_q;      end
			3'd4:    begin op_a = n_q;      op_b = db2_q;    end
			3'd5:    begin op_a = q2c_q;    op_b = d_q;      end
			3'd6:    begin op_a = n_q;      op_b = best_d_q; end
			default: begin op_a = best_n_q; op_b = d_q;      end
		endcase
		pp_lo = $signed({1'b0, op_a[LO_H-1:0]}) * op_b;
		pp_hi = $signed(op_a[LO_W-1:LO_H]) * op_b;
	end

	assign in_box = (prod_q[0] < prod_q[1]) && (prod_q[1] < prod_q[2]) &&
	                (prod_q[3] < prod_q[4]) && (prod_q[4] < prod_q[5]);
	assign better = !found_q || (prod_q[6] < prod_q[7]);

	assign best_mag = best_n_q[LO_W-1] ? LO_W'(-best_n_q) : LO_W'(best_n_q);
	assign rs       = {rem_q, dq_q[DIV_W-1]};
	assign rs_sub   = rs - (B_W+1)'($unsigned(best_d_q));
	assign big_q    = |dq_q[DIV_W-1:Q_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_DONE;
			found_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						if (command == CMD_NOP || count_q == '0) begin
							state_q <= S_END;
						end else begin
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: state_q <= S_CHECK;
				S_CHECK: begin
					if (cmd_q != CMD_PICK && rd_match) begin
						done_q   <= 1'b1;
						status_q <= ST_DONE;
						state_q  <= S_IDLE;
					end else if (cmd_q == CMD_PICK && rd_act) begin
						state_q <= S_LO;
					end else if (last_entry) begin
						state_q <= S_END;
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_LO: begin
					if (ax_q == 2'd2) begin
						state_q <= S_FACE;
					end
				end
				S_FACE: begin
					if (dir_a != '0) begin
						state_q <= S_MUL;
					end else if (face_q == FACE_LAST) begin
						state_q <= last_entry ? S_END : S_FETCH;
					end
				end
				S_MUL: begin
					if (step_q == 4'hF) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (in_box && better) begin
						found_q <= 1'b1;
					end
					if (face_q != FACE_LAST) begin
						state_q <= S_FACE;
					end else begin
						state_q <= last_entry ? S_END : S_FETCH;
					end
				end
				S_END: begin
					if (cmd_q == CMD_PICK && found_q) begin
						state_q <= S_DIV;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (cmd_q == CMD_PICK) begin
							status_q <= ST_MISS;
						end else if (cmd_q == CMD_ADD && !room) begin
							status_q <= ST_FULL;
						end else begin
							status_q <= ST_DONE;
						end
						if (cmd_q == CMD_ADD && room) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				S_DIV: begin
					if (dcnt_q == DCNT_W'(DIV_W - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					done_q   <= 1'b1;
					status_q <= ST_HIT;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q   <= command;
				cx_q    <= cell_x;
				cy_q    <= cell_y;
				cz_q    <= cell_z;
				src_x_q <= ray_origin_x;
				src_y_q <= ray_origin_y;
				src_z_q <= ray_origin_z;
				dir_x_q <= ray_dir_x;
				dir_y_q <= ray_dir_y;
				dir_z_q <= ray_dir_z;
				idx_q   <= '0;
				eidx_q     <= '0;
				face_out_q <= '0;
				depth_q    <= '0;
			end
			S_CHECK: begin
				ent_x_q <= rd_x;
				ent_y_q <= rd_y;
				ent_z_q <= rd_z;
				ax_q    <= 2'd0;
				face_q  <= '0;
				if (!(cmd_q == CMD_PICK && rd_act) && !last_entry) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_LO: begin
				case (ax_q)
					2'd0:    lo_x_q <= lo_new;
					2'd1:    lo_y_q <= lo_new;
					default: lo_z_q <= lo_new;
				endcase
				ax_q <= ax_q + 1'b1;
			end
			S_FACE: begin
				n_q    <= dir_a[Q_W-1] ? -n_raw : n_raw;
				d_q    <= dir_a[Q_W-1] ? -dir_a_ext : dir_a_ext;
				q1_q   <= lo_b1;
				q1c_q  <= lo_b1 + cs_ext;
				q2_q   <= lo_b2;
				q2c_q  <= lo_b2 + cs_ext;
				db1_q  <= opb_t'(dir_b1);
				db2_q  <= opb_t'(dir_b2);
				step_q <= '0;
				if (dir_a == '0) begin
					if (face_q == FACE_LAST) begin
						if (!last_entry) begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						face_q <= face_q + 1'b1;
					end
				end
			end
			S_MUL: begin
				if (!step_q[0]) begin
					pl_q <= pp_lo;
				end else begin
					prod_q[pk] <= (prod_t'(pp_hi) <<< LO_H) + prod_t'(pl_q);
				end
				step_q <= step_q + 1'b1;
			end
			S_DEC: begin
				if (in_box && better) begin
					best_n_q <= n_q;
					best_d_q <= d_q;
					best_i_q <= idx_q;
					best_f_q <= face_q;
				end
				if (face_q != FACE_LAST) begin
					face_q <= face_q + 1'b1;
				end else if (!last_entry) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_END: begin
				dq_q   <= DIV_W'(best_mag) << 16;
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			S_DIV: begin
				if (!rs_sub[B_W]) begin
					rem_q <= rs_sub[B_W-1:0];
					dq_q  <= {dq_q[DIV_W-2:0], 1'b1};
				end else begin
					rem_q <= rs[B_W-1:0];
					dq_q  <= {dq_q[DIV_W-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q + 1'b1;
			end
			S_OUT: begin
				eidx_q     <= best_i_q;
				face_out_q <= best_f_q;
				if (!best_n_q[LO_W-1]) begin
					depth_q <= big_q ? DEPTH_POS_MAX : dq_q[Q_W-1:0];
				end else begin
					depth_q <= big_q ? DEPTH_NEG_MAX : -dq_q[Q_W-1:0];
				end
			end
			default: begin
				step_q <= step_q;
			end
		endcase
	end

endmodule

[src/vsrp_chk.sv]
// ----------------------------------------------------------------------------
// vsrp_chk
// Port-level checks of the request and result sequencing and the hit face.
// ----------------------------------------------------------------------------
module vsrp_chk import vsrp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic [2:0] face
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken without going busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("request ended without a result");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");

	a_face: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_HIT |-> face <= FACE_LAST)
		else $error("hit face out of range");

endmodule

bind voxel_set_ray_pick vsrp_chk u_vsrp_chk (.*);
